// ===== design/lookat_pkg.sv =====
// ----------------------------------------------------------------------------
// lookat_pkg
// Shared constants and the arctangent table for the look-at angle pipeline.
// ----------------------------------------------------------------------------
package lookat_pkg;

  // Datapath widths
  localparam int ACC_W = 64;   // CORDIC x/y datapath
  localparam int ANG_W = 32;   // angle accumulator, 1/65536 degree
  localparam int ATAN_LEN = 24;

  // Angle constants
  localparam logic signed [ANG_W-1:0] DEG90 = 32'sd5898240;
  localparam int GAIN_Q16 = 107922;  // CORDIC gain in Q16
  localparam int YAW_LIMIT = 23040;
  localparam int PITCH_LIMIT = 11520;
  localparam int TURN = 46080;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // atan(2^-i) in 1/65536 degree
  function automatic ang_t atan_q16(input int i);
    case (i)
      0: atan_q16 = 32'sd2949120;
      1: atan_q16 = 32'sd1740967;
      2: atan_q16 = 32'sd919879;
      3: atan_q16 = 32'sd466945;
      4: atan_q16 = 32'sd234379;
      5: atan_q16 = 32'sd117304;
      6: atan_q16 = 32'sd58666;
      7: atan_q16 = 32'sd29335;
      8: atan_q16 = 32'sd14668;
      9: atan_q16 = 32'sd7334;
      10: atan_q16 = 32'sd3667;
      11: atan_q16 = 32'sd1833;
      12: atan_q16 = 32'sd917;
      13: atan_q16 = 32'sd458;
      14: atan_q16 = 32'sd229;
      15: atan_q16 = 32'sd115;
      16: atan_q16 = 32'sd57;
      17: atan_q16 = 32'sd29;
      18: atan_q16 = 32'sd14;
      19: atan_q16 = 32'sd7;
      20: atan_q16 = 32'sd4;
      21: atan_q16 = 32'sd2;
      22: atan_q16 = 32'sd1;
      default: atan_q16 = 32'sd0;
    endcase
  endfunction

  // 1/65536 degree accumulator to saturated 1/128 degree, rounded
  function automatic logic signed [15:0] to_units(input ang_t z, input int limit);
    ang_t a;
    a = (z + 32'sd256) >>> 9;
    if (a > ang_t'(limit)) a = ang_t'(limit);
    if (a < -ang_t'(limit)) a = -ang_t'(limit);
    to_units = a[15:0];
  endfunction

endpackage

// ===== design/look_at_yaw_pitch_angles.sv =====
// ----------------------------------------------------------------------------
// look_at_yaw_pitch_angles
// Yaw and pitch from a source point toward a target point, CORDIC pipeline.
// ----------------------------------------------------------------------------
//  Channel | Dir | Beat contents
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | src_x, src_y, src_z, dst_x, dst_y, dst_z, prev_yaw
//  m_*     | out | pitch, yaw
//
//  One beat per cycle in and out unless the output stalls; each beat
//  passes the yaw vectoring stages followed by the pitch vectoring stages.
//  rst clears every valid bit; payload registers are not reset.
//  When m_tvalid is high and m_tready low, the whole pipeline holds and
//  s_tready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module look_at_yaw_pitch_angles #(
  parameter int COORD_WIDTH = 24,
  parameter int COORD_FRAC_BITS = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // src_x, src_y, src_z, dst_x, dst_y, dst_z, prev_yaw[17:0]
  input  logic [((6*COORD_WIDTH+18+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // pitch[14:0], yaw[17:0]
  output logic [39:0] m_tdata
);
  import lookat_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int P = 59 - COORD_WIDTH;
  localparam int S = CORDIC_STEPS;
  localparam acc_t FAR_LIM = -(64'sd360 <<< COORD_FRAC_BITS);

  logic en;

  // Input field slices
  logic signed [CW-1:0] src_x, src_y, src_z, dst_x, dst_y, dst_z;
  logic signed [17:0] prev_yaw;
  assign src_x = s_tdata[0*CW +: CW];
  assign src_y = s_tdata[1*CW +: CW];
  assign src_z = s_tdata[2*CW +: CW];
  assign dst_x = s_tdata[3*CW +: CW];
  assign dst_y = s_tdata[4*CW +: CW];
  assign dst_z = s_tdata[5*CW +: CW];
  assign prev_yaw = s_tdata[6*CW +: 18];

  // Stage A: differences
  logic va;
  logic signed [DW-1:0] dx, dy, dz;
  logic signed [17:0] prev_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
    if (en) begin
      dx <= DW'(dst_x) - DW'(src_x);
      dy <= DW'(dst_y) - DW'(src_y);
      dz <= DW'(dst_z) - DW'(src_z);
      prev_a <= prev_yaw;
    end
  end

  // Stage B: prerotation into the right half plane, pitch y product
  logic vb_in;
  acc_t x0, y0, dx64, dy64;
  ang_t z0;
  logic signed [DW+18-1:0] gprod;
  assign vb_in = va;
  assign dx64 = acc_t'(dx) <<< P;
  assign dy64 = acc_t'(dy) <<< P;
  assign gprod = -((DW+18)'(dz) * (DW+18)'(GAIN_Q16));

  always_comb begin
    x0 = dx64;
    y0 = dy64;
    z0 = '0;
    if (dx64 < 0) begin
      if (dy64 >= 0) begin
        x0 = dy64;
        y0 = -dx64;
        z0 = DEG90;
      end else begin
        x0 = -dy64;
        y0 = dx64;
        z0 = -DEG90;
      end
    end
  end

  // Pipeline stage arrays: yaw pass 0..S, pitch pass 0..S
  logic v_y [0:S];
  acc_t yx [0:S];
  acc_t yy [0:S];
  ang_t yz [0:S];
  acc_t gy [0:S];
  logic nz_y [0:S];
  logic far_y [0:S];
  logic signed [17:0] prev_y [0:S];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_y[0] <= 1'b0;
    end else if (en) begin
      v_y[0] <= vb_in;
    end
    if (en) begin
      yx[0] <= x0;
      yy[0] <= y0;
      yz[0] <= z0;
      gy[0] <= acc_t'(gprod) <<< (P - 16);
      nz_y[0] <= (dx != '0) || (dy != '0);
      far_y[0] <= acc_t'(dx) <= FAR_LIM;
      prev_y[0] <= prev_a;
    end
  end

  // Yaw vectoring stages
  for (genvar k = 0; k < S; k++) begin : g_yaw
    acc_t xs, ys;
    assign xs = yx[k] >>> k;
    assign ys = yy[k] >>> k;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_y[k+1] <= 1'b0;
      end else if (en) begin
        v_y[k+1] <= v_y[k];
      end
      if (en) begin
        if (yy[k] < 0) begin
          yx[k+1] <= yx[k] - ys;
          yy[k+1] <= yy[k] + xs;
          yz[k+1] <= yz[k] - atan_q16(k);
        end else begin
          yx[k+1] <= yx[k] + ys;
          yy[k+1] <= yy[k] - xs;
          yz[k+1] <= yz[k] + atan_q16(k);
        end
        gy[k+1] <= gy[k];
        nz_y[k+1] <= nz_y[k];
        far_y[k+1] <= far_y[k];
        prev_y[k+1] <= prev_y[k];
      end
    end
  end

  // Pitch vectoring stages, starting from the gained yaw magnitude
  logic v_p [0:S];
  acc_t px [0:S];
  acc_t py [0:S];
  ang_t pz [0:S];
  ang_t yaw_z [0:S];
  logic nz_p [0:S];
  logic far_p [0:S];
  logic signed [17:0] prev_p [0:S];

  assign v_p[0] = v_y[S];
  assign px[0] = yx[S];
  assign py[0] = gy[S];
  assign pz[0] = '0;
  assign yaw_z[0] = yz[S];
  assign nz_p[0] = nz_y[S];
  assign far_p[0] = far_y[S];
  assign prev_p[0] = prev_y[S];

  for (genvar k = 0; k < S; k++) begin : g_pitch
    acc_t xs, ys;
    assign xs = px[k] >>> k;
    assign ys = py[k] >>> k;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[k+1] <= 1'b0;
      end else if (en) begin
        v_p[k+1] <= v_p[k];
      end
      if (en) begin
        if (py[k] < 0) begin
          px[k+1] <= px[k] - ys;
          py[k+1] <= py[k] + xs;
          pz[k+1] <= pz[k] - atan_q16(k);
        end else begin
          px[k+1] <= px[k] + ys;
          py[k+1] <= py[k] - xs;
          pz[k+1] <= pz[k] + atan_q16(k);
        end
        yaw_z[k+1] <= yaw_z[k];
        nz_p[k+1] <= nz_p[k];
        far_p[k+1] <= far_p[k];
        prev_p[k+1] <= prev_p[k];
      end
    end
  end

  // Stage F1: degree units, far-negative quirk, zero vector
  logic vf;
  logic signed [19:0] yaw_f;
  logic signed [14:0] pitch_f;
  logic signed [17:0] prev_f;
  logic signed [15:0] yaw_u, pitch_u;
  assign yaw_u = to_units(yaw_z[S], YAW_LIMIT);
  assign pitch_u = to_units(pz[S], PITCH_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= v_p[S];
    end
    if (en) begin
      prev_f <= prev_p[S];
      if (!nz_p[S]) begin
        yaw_f <= '0;
        pitch_f <= '0;
      end else begin
        yaw_f <= far_p[S] ? 20'(yaw_u) - 20'sd46080 : 20'(yaw_u);
        pitch_f <= pitch_u[14:0];
      end
    end
  end

  // Stage F2: single wrap toward previous yaw, output register
  logic signed [19:0] len;
  logic signed [19:0] yaw_w;
  logic signed [14:0] pitch_o;
  logic signed [17:0] yaw_o;
  assign len = yaw_f - 20'(prev_f);

  always_comb begin
    yaw_w = yaw_f;
    if (len >= 20'(YAW_LIMIT)) begin
      yaw_w = yaw_f - 20'(TURN);
    end else if (len <= -20'(YAW_LIMIT)) begin
      yaw_w = yaw_f + 20'(TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vf;
    end
    if (en) begin
      pitch_o <= pitch_f;
      yaw_o <= yaw_w[17:0];
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tdata = {7'b0, yaw_o, pitch_o};

`ifndef ASSERT_OFF
  // held output beat stalls the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output stalled");

  // pitch stays within plus/minus 90 degrees
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_o <= 15'sd11520 && pitch_o >= -15'sd11520))
    else $error("pitch out of range");

  // held beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // zero horizontal vector gives zero pitch
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (en && v_p[S] && !nz_p[S]) |=> (pitch_f == '0))
    else $error("pitch not zero for vertical vector");
`endif

endmodule
